// ----- src/ieba_pkg.sv -----
package ieba_pkg;

	// Sequencer phase codes; the byte blocks span seven consecutive codes each
	typedef logic [5:0] phase_t;

	localparam phase_t PH_IDLE  = 6'd0;
	localparam phase_t PH_S1    = 6'd1;
	localparam phase_t PH_S2    = 6'd2;
	localparam phase_t PH_S3    = 6'd3;
	localparam phase_t BLK_DEVW = 6'd4;
	localparam phase_t BLK_ADDR = 6'd11;
	localparam phase_t BLK_DATA = 6'd18;
	localparam phase_t PH_R1    = 6'd25;
	localparam phase_t PH_R2    = 6'd26;
	localparam phase_t PH_R3    = 6'd27;
	localparam phase_t BLK_DEVR = 6'd28;
	localparam phase_t PH_RL    = 6'd35;
	localparam phase_t PH_RR    = 6'd36;
	localparam phase_t PH_RH    = 6'd37;
	localparam phase_t PH_RS    = 6'd38;
	localparam phase_t PH_NH    = 6'd39;
	localparam phase_t PH_NL    = 6'd40;
	localparam phase_t PH_P1    = 6'd41;
	localparam phase_t PH_P2    = 6'd42;
	localparam phase_t PH_P3    = 6'd43;

	// Step within a byte block
	typedef logic [2:0] blk_off_t;

	localparam blk_off_t OFF_SCL_LO   = 3'd0;
	localparam blk_off_t OFF_SDA_BIT  = 3'd1;
	localparam blk_off_t OFF_SCL_HI   = 3'd2;
	localparam blk_off_t OFF_ACK_LO   = 3'd3;
	localparam blk_off_t OFF_ACK_REL  = 3'd4;
	localparam blk_off_t OFF_ACK_HI   = 3'd5;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// Item kinds
	localparam logic MODE_CMD  = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// Configuration register indexes
	typedef logic [1:0] cfg_idx_t;

	localparam cfg_idx_t REG_DEVICE_SELECT  = 2'd0;
	localparam cfg_idx_t REG_ACK_WAIT_LIMIT = 2'd1;

	localparam logic [6:0] DEVICE_SELECT_RST  = 7'd80;
	localparam logic [7:0] ACK_WAIT_LIMIT_RST = 8'd250;

	typedef struct packed {
		logic [6:0] device_select;
		logic [7:0] ack_wait_limit;
	} cfg_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rd_data;
	} res_t;

endpackage

// ----- src/ieba_req_if.sv -----
interface ieba_req_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic       write_request;
	logic [7:0] word_address;
	logic [7:0] write_data;
	logic       sda_in;

	modport source (
		output valid, mode, write_request, word_address, write_data, sda_in,
		input  ready
	);

	modport sink (
		input  valid, mode, write_request, word_address, write_data, sda_in,
		output ready
	);
endinterface

// ----- src/ieba_res_if.sv -----
interface ieba_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_byte_out;

	modport source (
		output valid, scl_level, sda_level, busy_res, done_res, read_byte_out,
		input  ready
	);

	modport sink (
		input  valid, scl_level, sda_level, busy_res, done_res, read_byte_out,
		output ready
	);
endinterface

// ----- src/ieba_cfg.sv -----
module ieba_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  ieba_pkg::cfg_idx_t cfg_index,
	input  logic [7:0]        cfg_data,
	output ieba_pkg::cfg_t    cfg
);
	import ieba_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_select  <= DEVICE_SELECT_RST;
			cfg_q.ack_wait_limit <= ACK_WAIT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEVICE_SELECT:  cfg_q.device_select  <= cfg_data[6:0];
				REG_ACK_WAIT_LIMIT: cfg_q.ack_wait_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/ieba_seq.sv -----
module ieba_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic            mode,
	input  logic            write_request,
	input  logic [7:0]      word_address,
	input  logic [7:0]      write_data,
	input  logic            sda_in,
	input  ieba_pkg::cfg_t  cfg,
	output ieba_pkg::res_t  res_nxt
);
	import ieba_pkg::*;

	phase_t     phase_q, phase_d;
	logic [3:0] bit_cnt_q, bit_cnt_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] ack_cnt_q, ack_cnt_d;
	logic       is_write_q, is_write_d;
	logic [7:0] addr_q, addr_d;
	logic [7:0] data_q, data_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic [7:0] rd_q, rd_d;
	logic       done;

	// Byte block decode
	logic       in_blk;
	phase_t     blk_base;
	phase_t     blk_after;
	phase_t     blk_diff;
	blk_off_t   blk_off;

	logic       do_enter;
	phase_t     enter_tgt;
	logic [3:0] bit_cnt_inc;
	logic [7:0] shift_in;

	always_comb begin
		in_blk    = 1'b1;
		blk_base  = BLK_DEVW;
		blk_after = BLK_ADDR;
		if (phase_q >= BLK_DEVW && phase_q < BLK_ADDR) begin
			blk_base  = BLK_DEVW;
			blk_after = BLK_ADDR;
		end else if (phase_q >= BLK_ADDR && phase_q < BLK_DATA) begin
			blk_base  = BLK_ADDR;
			blk_after = is_write_q ? BLK_DATA : PH_R1;
		end else if (phase_q >= BLK_DATA && phase_q < PH_R1) begin
			blk_base  = BLK_DATA;
			blk_after = PH_P1;
		end else if (phase_q >= BLK_DEVR && phase_q < PH_RL) begin
			blk_base  = BLK_DEVR;
			blk_after = PH_RL;
		end else begin
			in_blk = 1'b0;
		end
		blk_diff = phase_q - blk_base;
		blk_off  = blk_diff[2:0];
	end

	assign bit_cnt_inc = bit_cnt_q + 4'd1;
	assign shift_in    = {shift_q[6:0], sda_in};

	always_comb begin
		phase_d    = phase_q;
		bit_cnt_d  = bit_cnt_q;
		shift_d    = shift_q;
		ack_cnt_d  = ack_cnt_q;
		is_write_d = is_write_q;
		addr_d     = addr_q;
		data_d     = data_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		rd_d       = rd_q;
		done       = 1'b0;
		do_enter   = 1'b0;
		enter_tgt  = PH_IDLE;

		if (mode == MODE_CMD) begin
			if (phase_q == PH_IDLE) begin
				is_write_d = write_request;
				addr_d     = word_address;
				data_d     = write_data;
				phase_d    = PH_S1;
			end
		end else if (phase_q != PH_IDLE) begin
			if (in_blk) begin
				case (blk_off)
					OFF_SCL_LO: begin
						scl_d   = 1'b0;
						phase_d = phase_q + 6'd1;
					end
					OFF_SDA_BIT: begin
						sda_d   = shift_q[7];
						shift_d = {shift_q[6:0], 1'b0};
						phase_d = phase_q + 6'd1;
					end
					OFF_SCL_HI: begin
						scl_d     = 1'b1;
						bit_cnt_d = bit_cnt_inc;
						phase_d   = (bit_cnt_inc >= BITS_PER_BYTE) ?
							phase_q + 6'd1 : blk_base;
					end
					OFF_ACK_LO: begin
						scl_d   = 1'b0;
						phase_d = phase_q + 6'd1;
					end
					OFF_ACK_REL: begin
						sda_d   = 1'b1;
						phase_d = phase_q + 6'd1;
					end
					OFF_ACK_HI: begin
						scl_d     = 1'b1;
						ack_cnt_d = 8'd0;
						phase_d   = phase_q + 6'd1;
					end
					default: begin
						// Acknowledge wait: SDA low or limit reached ends the clock
						if (sda_in && ack_cnt_q < cfg.ack_wait_limit) begin
							ack_cnt_d = ack_cnt_q + 8'd1;
						end else begin
							scl_d     = 1'b0;
							do_enter  = 1'b1;
							enter_tgt = blk_after;
						end
					end
				endcase
			end else if (phase_q == PH_S1 || phase_q == PH_R1) begin
				sda_d   = 1'b1;
				phase_d = phase_q + 6'd1;
			end else if (phase_q == PH_S2 || phase_q == PH_R2) begin
				scl_d   = 1'b1;
				phase_d = phase_q + 6'd1;
			end else if (phase_q == PH_S3) begin
				sda_d     = 1'b0;
				do_enter  = 1'b1;
				enter_tgt = BLK_DEVW;
			end else if (phase_q == PH_R3) begin
				sda_d     = 1'b0;
				do_enter  = 1'b1;
				enter_tgt = BLK_DEVR;
			end else if (phase_q == PH_RL) begin
				scl_d   = 1'b0;
				phase_d = PH_RR;
			end else if (phase_q == PH_RR) begin
				sda_d     = 1'b1;
				bit_cnt_d = 4'd0;
				shift_d   = 8'd0;
				phase_d   = PH_RH;
			end else if (phase_q == PH_RH) begin
				scl_d   = 1'b1;
				phase_d = PH_RS;
			end else if (phase_q == PH_RS) begin
				shift_d   = shift_in;
				scl_d     = 1'b0;
				bit_cnt_d = bit_cnt_inc;
				if (bit_cnt_inc >= BITS_PER_BYTE) begin
					rd_d    = shift_in;
					phase_d = PH_NH;
				end else begin
					phase_d = PH_RH;
				end
			end else if (phase_q == PH_NH) begin
				sda_d   = 1'b1;
				scl_d   = 1'b1;
				phase_d = PH_NL;
			end else if (phase_q == PH_NL) begin
				scl_d   = 1'b0;
				phase_d = PH_P1;
			end else if (phase_q == PH_P1) begin
				sda_d   = 1'b0;
				phase_d = PH_P2;
			end else if (phase_q == PH_P2) begin
				scl_d   = 1'b1;
				phase_d = PH_P3;
			end else if (phase_q == PH_P3) begin
				sda_d   = 1'b1;
				phase_d = PH_IDLE;
				done    = 1'b1;
			end else begin
				phase_d = PH_IDLE;
			end

			// Entering a byte block loads the byte to shift out
			if (do_enter) begin
				phase_d = enter_tgt;
				case (enter_tgt)
					BLK_DEVW: begin
						shift_d   = {cfg.device_select, 1'b0};
						bit_cnt_d = 4'd0;
					end
					BLK_ADDR: begin
						shift_d   = addr_q;
						bit_cnt_d = 4'd0;
					end
					BLK_DATA: begin
						shift_d   = data_q;
						bit_cnt_d = 4'd0;
					end
					BLK_DEVR: begin
						shift_d   = {cfg.device_select, 1'b1};
						bit_cnt_d = 4'd0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bit_cnt_q  <= 4'd0;
			shift_q    <= 8'd0;
			ack_cnt_q  <= 8'd0;
			is_write_q <= 1'b0;
			addr_q     <= 8'd0;
			data_q     <= 8'd0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			rd_q       <= 8'd0;
		end else if (accept) begin
			phase_q    <= phase_d;
			bit_cnt_q  <= bit_cnt_d;
			shift_q    <= shift_d;
			ack_cnt_q  <= ack_cnt_d;
			is_write_q <= is_write_d;
			addr_q     <= addr_d;
			data_q     <= data_d;
			scl_q      <= scl_d;
			sda_q      <= sda_d;
			rd_q       <= rd_d;
		end
	end

	always_comb begin
		res_nxt.scl     = scl_d;
		res_nxt.sda     = sda_d;
		res_nxt.busy    = (phase_d != PH_IDLE);
		res_nxt.done    = done;
		res_nxt.rd_data = rd_d;
	end

endmodule

// ----- src/i2c_eeprom_byte_access_master.sv -----
// Channel   Dir  Beat contents
// --------  ---  -----------------------------------------------------------
// req       in   mode, write_request, word_address, write_data, sda_in
// res       out  scl_level, sda_level, busy_res, done_res, read_byte_out
// cfg_*     in   cfg_we, cfg_index, cfg_data (device_select, ack_wait_limit)
//
// One cycle per item: a req beat updates the sequencer state and loads the
// result register at the same edge, so a beat may be taken every cycle.
// Every req beat yields exactly one res beat.
// The result register parts the two sides: req is taken whenever the register
// is empty or is being drained in the same cycle; a stalled res holds its beat.
// arst_n clears the sequencer to idle with both lines released high.
module i2c_eeprom_byte_access_master (
	input  logic               clk,
	input  logic               arst_n,
	ieba_req_if.sink           req,
	ieba_res_if.source         res,
	input  logic               cfg_we,
	input  ieba_pkg::cfg_idx_t cfg_index,
	input  logic [7:0]         cfg_data
);
	import ieba_pkg::*;

	cfg_t cfg;
	res_t res_nxt;
	res_t res_q;
	logic res_valid_q;
	logic accept;

	// Take a beat when the result register is free or drains this cycle
	assign req.ready = !res_valid_q || res.ready;
	assign accept    = req.valid && req.ready;

	ieba_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Bus sequencer: state registers plus one step of next-phase logic
	ieba_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.mode          (req.mode),
		.write_request (req.write_request),
		.word_address  (req.word_address),
		.write_data    (req.write_data),
		.sda_in        (req.sda_in),
		.cfg           (cfg),
		.res_nxt       (res_nxt)
	);

	// Result register: load on accept, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_nxt;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.scl_level     = res_q.scl;
	assign res.sda_level     = res_q.sda;
	assign res.busy_res      = res_q.busy;
	assign res.done_res      = res_q.done;
	assign res.read_byte_out = res_q.rd_data;

endmodule

// ----- src/ieba_checker.sv -----
module ieba_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic       scl_level,
	input logic       sda_level,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_byte_out
);

	// A finished access leaves the bus idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res)
		else $error("done beat still reports busy");

	// Stop condition leaves both lines released
	a_done_lines: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> scl_level && sda_level)
		else $error("done beat with a line held low");

	// Empty result register never blocks the input side
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> req_ready)
		else $error("input stalled with empty result register");

	// Stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(scl_level)
			&& $stable(sda_level) && $stable(busy_res) && $stable(done_res)
			&& $stable(read_byte_out))
		else $error("stalled result beat changed");

endmodule

bind i2c_eeprom_byte_access_master ieba_checker u_ieba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_ready     (req.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.scl_level     (res.scl_level),
	.sda_level     (res.sda_level),
	.busy_res      (res.busy_res),
	.done_res      (res.done_res),
	.read_byte_out (res.read_byte_out)
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import ieba_pkg::*;

	// Give up once this many cycles pass with no beat moving on either side
	localparam int STALL_LIMIT = 2000;
	// Receiver hold-off: start once this many result beats have gone by
	localparam int HOLD_AFTER  = 600;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 10;

	// Unmapped register indexes: writes to these must leave the block untouched
	localparam cfg_idx_t REG_UNMAPPED_LO = 2'd2;
	localparam cfg_idx_t REG_UNMAPPED_HI = 2'd3;

	// Receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_HALF,
		RX_QUARTER,
		RX_RANDOM
	} rx_style_t;

	typedef struct packed {
		logic       mode;
		logic       write_request;
		logic [7:0] word_address;
		logic [7:0] write_data;
		logic       sda_in;
	} req_beat_t;

	// One stimulus beat, with an optional result typed in by hand
	typedef struct packed {
		req_beat_t beat;
		logic      typed;
		res_t      want;
	} row_t;

	// Sequencer state as the predictor keeps it
	typedef struct packed {
		phase_t     ph;
		logic [3:0] bits;
		logic [7:0] shreg;
		logic [7:0] wait_cnt;
		logic       wr;
		logic [7:0] addr;
		logic [7:0] data;
		logic       scl;
		logic       sda;
		logic [7:0] rd;
	} bus_state_t;

	// Line levels that can be read straight off the start of an access
	localparam res_t REST_IDLE  = {1'b1, 1'b1, 1'b0, 1'b0, 8'h00};
	localparam res_t REST_BUSY  = {1'b1, 1'b1, 1'b1, 1'b0, 8'h00};
	localparam res_t START_LOW  = {1'b1, 1'b0, 1'b1, 1'b0, 8'h00};
	localparam res_t CLOCK_LOW  = {1'b0, 1'b0, 1'b1, 1'b0, 8'h00};

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [7:0] cfg_data;

	ieba_req_if req_ch ();
	ieba_res_if res_ch ();

	i2c_eeprom_byte_access_master u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Stimulus waiting to go out, and the line levels each sent beat must produce
	row_t bus_items [$];
	res_t levels_due [$];

	// Predictor state: one copy tracks accepted beats, the other runs ahead
	// while stimulus is built so that accesses can be shaped to completion
	bus_state_t bus_model;
	bus_state_t bus_lookahead;
	cfg_t       bus_cfg;

	int mismatches;
	int rx_beats;
	int stall_cycles;

	// Sender burst shaping
	int burst_left;
	int gap_left;
	row_t taken;
	res_t foreseen;

	// Receiver stall shaping
	int rx_tick;
	int hold_left;
	bit hold_used;
	rx_style_t rx_style;

	row_t opening [24];

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic bus_state_t reset_bus();
		bus_state_t s;
		s = '0;
		s.ph  = PH_IDLE;
		s.scl = 1'b1;
		s.sda = 1'b1;
		return s;
	endfunction

	// Enter a phase; a byte block also loads its shift register
	function automatic void load_block(inout bus_state_t s, input cfg_t c, input phase_t p);
		s.ph = p;
		if (p == BLK_DEVW) begin
			s.shreg = {c.device_select, 1'b0};
			s.bits  = '0;
		end else if (p == BLK_ADDR) begin
			s.shreg = s.addr;
			s.bits  = '0;
		end else if (p == BLK_DATA) begin
			s.shreg = s.data;
			s.bits  = '0;
		end else if (p == BLK_DEVR) begin
			s.shreg = {c.device_select, 1'b1};
			s.bits  = '0;
		end
	endfunction

	// One tick inside a byte-send block: eight data clocks, then the acknowledge clock
	function automatic void byte_step(inout bus_state_t s, input cfg_t c,
			input phase_t base, input phase_t after, input logic sda_in);
		phase_t rel;
		blk_off_t off;
		rel = s.ph - base;
		off = rel[2:0];
		case (off)
			OFF_SCL_LO: begin
				s.scl = 1'b0;
				s.ph  = base + 6'd1;
			end
			OFF_SDA_BIT: begin
				s.sda   = s.shreg[7];
				s.shreg = {s.shreg[6:0], 1'b0};
				s.ph    = base + 6'd2;
			end
			OFF_SCL_HI: begin
				s.scl  = 1'b1;
				s.bits = s.bits + 4'd1;
				s.ph   = (s.bits >= BITS_PER_BYTE) ? base + 6'd3 : base;
			end
			OFF_ACK_LO: begin
				s.scl = 1'b0;
				s.ph  = base + 6'd4;
			end
			OFF_ACK_REL: begin
				s.sda = 1'b1;
				s.ph  = base + 6'd5;
			end
			OFF_ACK_HI: begin
				s.scl      = 1'b1;
				s.wait_cnt = '0;
				s.ph       = base + 6'd6;
			end
			default: begin
				// Wait with SCL high until the slave pulls SDA low or patience runs out
				if (sda_in && s.wait_cnt < c.ack_wait_limit) begin
					s.wait_cnt = s.wait_cnt + 8'd1;
				end else begin
					s.scl = 1'b0;
					load_block(s, c, after);
				end
			end
		endcase
	endfunction

	// Advance the sequencer by one beat and return the line levels it leaves
	function automatic res_t advance_bus(inout bus_state_t s, input cfg_t c,
			input req_beat_t b);
		res_t r;
		logic done;
		done = 1'b0;
		if (b.mode == MODE_CMD) begin
			// Commands only land while idle; the lines wait for the next tick
			if (s.ph == PH_IDLE) begin
				s.wr   = b.write_request;
				s.addr = b.word_address;
				s.data = b.write_data;
				s.ph   = PH_S1;
			end
		end else if (s.ph != PH_IDLE) begin
			if (s.ph == PH_S1) begin
				s.sda = 1'b1;
				s.ph  = PH_S2;
			end else if (s.ph == PH_S2) begin
				s.scl = 1'b1;
				s.ph  = PH_S3;
			end else if (s.ph == PH_S3) begin
				s.sda = 1'b0;
				load_block(s, c, BLK_DEVW);
			end else if (s.ph >= BLK_DEVW && s.ph < BLK_ADDR) begin
				byte_step(s, c, BLK_DEVW, BLK_ADDR, b.sda_in);
			end else if (s.ph >= BLK_ADDR && s.ph < BLK_DATA) begin
				byte_step(s, c, BLK_ADDR, s.wr ? BLK_DATA : PH_R1, b.sda_in);
			end else if (s.ph >= BLK_DATA && s.ph < PH_R1) begin
				byte_step(s, c, BLK_DATA, PH_P1, b.sda_in);
			end else if (s.ph == PH_R1) begin
				s.sda = 1'b1;
				s.ph  = PH_R2;
			end else if (s.ph == PH_R2) begin
				s.scl = 1'b1;
				s.ph  = PH_R3;
			end else if (s.ph == PH_R3) begin
				s.sda = 1'b0;
				load_block(s, c, BLK_DEVR);
			end else if (s.ph >= BLK_DEVR && s.ph < PH_RL) begin
				byte_step(s, c, BLK_DEVR, PH_RL, b.sda_in);
			end else if (s.ph == PH_RL) begin
				s.scl = 1'b0;
				s.ph  = PH_RR;
			end else if (s.ph == PH_RR) begin
				s.sda   = 1'b1;
				s.bits  = '0;
				s.shreg = '0;
				s.ph    = PH_RH;
			end else if (s.ph == PH_RH) begin
				s.scl = 1'b1;
				s.ph  = PH_RS;
			end else if (s.ph == PH_RS) begin
				// Shift in MSB first; the read byte only moves after the eighth bit
				s.shreg = {s.shreg[6:0], b.sda_in};
				s.scl   = 1'b0;
				s.bits  = s.bits + 4'd1;
				if (s.bits >= BITS_PER_BYTE) begin
					s.rd = s.shreg;
					s.ph = PH_NH;
				end else begin
					s.ph = PH_RH;
				end
			end else if (s.ph == PH_NH) begin
				s.sda = 1'b1;
				s.scl = 1'b1;
				s.ph  = PH_NL;
			end else if (s.ph == PH_NL) begin
				s.scl = 1'b0;
				s.ph  = PH_P1;
			end else if (s.ph == PH_P1) begin
				s.sda = 1'b0;
				s.ph  = PH_P2;
			end else if (s.ph == PH_P2) begin
				s.scl = 1'b1;
				s.ph  = PH_P3;
			end else if (s.ph == PH_P3) begin
				s.sda = 1'b1;
				s.ph  = PH_IDLE;
				done  = 1'b1;
			end else begin
				s.ph = PH_IDLE;
			end
		end
		r.scl     = s.scl;
		r.sda     = s.sda;
		r.busy    = (s.ph != PH_IDLE);
		r.done    = done;
		r.rd_data = s.rd;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic row_t mk_row(logic mode, logic wr, logic [7:0] addr,
			logic [7:0] data, logic sda, logic typed, res_t want);
		row_t r;
		r.beat.mode          = mode;
		r.beat.write_request = wr;
		r.beat.word_address  = addr;
		r.beat.write_data    = data;
		r.beat.sda_in        = sda;
		r.typed              = typed;
		r.want               = want;
		return r;
	endfunction

	// Queue a beat for the sender and run the look-ahead copy over it
	task automatic queue_item(row_t r);
		bus_items.push_back(r);
		void'(advance_bus(bus_lookahead, bus_cfg, r.beat));
	endtask

	// Hold until every queued beat has gone out and every result has come back
	task automatic settle_bus();
		while (bus_items.size() != 0 || levels_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Drive one register write; the block takes it at the following edge
	task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DEVICE_SELECT)
			bus_cfg.device_select = val[6:0];
		else if (idx == REG_ACK_WAIT_LIMIT)
			bus_cfg.ack_wait_limit = val;
	endtask

	task automatic set_config(logic [6:0] dev, logic [7:0] limit);
		settle_bus();
		write_reg(REG_DEVICE_SELECT, {1'b0, dev});
		write_reg(REG_ACK_WAIT_LIMIT, limit);
	endtask

	// Build mostly complete accesses with random content. The acknowledge and
	// read data come from sda_in, high with the given percentage. Idle ticks
	// and commands thrown at a busy block are sprinkled in and not counted.
	task automatic run_phase(int n_items, int high_pct);
		int count;
		req_beat_t b;
		count = 0;
		while (count < n_items) begin
			b.word_address  = 8'($urandom);
			b.write_data    = 8'($urandom);
			b.write_request = 1'($urandom);
			b.sda_in        = 1'($urandom);
			if (bus_lookahead.ph == PH_IDLE) begin
				if ($urandom_range(4) == 0) begin
					b.mode = MODE_TICK;
				end else begin
					b.mode = MODE_CMD;
					count++;
				end
			end else if ($urandom_range(39) == 0) begin
				b.mode = MODE_CMD;
			end else begin
				b.mode   = MODE_TICK;
				b.sda_in = ($urandom_range(99) < high_pct);
				count++;
			end
			queue_item(mk_row(b.mode, b.write_request, b.word_address, b.write_data,
				b.sda_in, 1'b0, '0));
		end
		settle_bus();
	endtask

	// ------------------------------------------------------------------
	// Clock and main sequence
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_DEVICE_SELECT;
		cfg_data       = 8'h00;
		req_ch.valid         = 1'b0;
		req_ch.mode          = MODE_TICK;
		req_ch.write_request = 1'b0;
		req_ch.word_address  = 8'h00;
		req_ch.write_data    = 8'h00;
		req_ch.sda_in        = 1'b1;
		res_ch.ready         = 1'b0;
		bus_cfg.device_select  = DEVICE_SELECT_RST;
		bus_cfg.ack_wait_limit = ACK_WAIT_LIMIT_RST;
		bus_model     = reset_bus();
		bus_lookahead = reset_bus();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Opening table: idle ticks, a write command with all-ones fields,
		// a command refused while busy, the start condition, then a stretch
		// of the device byte left to the predictor
		opening = '{
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1, REST_IDLE),
			mk_row(MODE_TICK, 1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1, REST_IDLE),
			mk_row(MODE_CMD,  1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1, REST_BUSY),
			mk_row(MODE_CMD,  1'b0, 8'h00, 8'h00, 1'b0, 1'b1, REST_BUSY),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1, REST_BUSY),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b1, 1'b1, REST_BUSY),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1, START_LOW),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b1, 1'b1, CLOCK_LOW),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, '0),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0, '0),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, '0),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0, '0),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0, '0),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, '0),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, '0),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0, '0),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, '0),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0, '0),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, '0),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0, '0),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, '0),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0, '0),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, '0),
			mk_row(MODE_TICK, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0, '0)
		};
		foreach (opening[i])
			queue_item(opening[i]);
		settle_bus();

		// Highest device address; a zero limit ends each acknowledge at once
		set_config(7'd127, 8'd0);
		run_phase(300, 50);

		// Lowest device address with the longest wait; acks mostly come quickly
		set_config(7'd0, 8'd255);
		run_phase(300, 25);

		// SDA stuck high: every acknowledge times out and reads return all ones
		set_config(7'($urandom), 8'd3);
		run_phase(300, 100);

		// SDA stuck low: every byte acknowledged and reads return zero
		set_config(7'($urandom), 8'($urandom_range(1, 8)));
		run_phase(300, 0);

		// Writes to unmapped indexes must be dropped; then back to reset values
		settle_bus();
		write_reg(REG_UNMAPPED_LO, 8'($urandom));
		write_reg(REG_UNMAPPED_HI, 8'($urandom));
		set_config(DEVICE_SELECT_RST, ACK_WAIT_LIMIT_RST);
		run_phase(300, 45);

		set_config(7'($urandom), 8'($urandom));
		run_phase(300, $urandom_range(0, 60));

		settle_bus();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && levels_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// Sender: bursts of random length with random gaps between them
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			burst_left   <= 0;
			gap_left     <= 0;
		end else begin
			// Predict on every accepted beat; a hand-typed result takes precedence
			if (req_ch.valid && req_ch.ready) begin
				taken    = bus_items.pop_front();
				foreseen = advance_bus(bus_model, bus_cfg, taken.beat);
				levels_due.push_back(taken.typed ? taken.want : foreseen);
			end
			// Hold a beat that is still waiting; otherwise pick the next move
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (gap_left != 0) begin
					gap_left     = gap_left - 1;
					req_ch.valid <= 1'b0;
				end else if (bus_items.size() == 0) begin
					req_ch.valid <= 1'b0;
				end else begin
					req_ch.valid         <= 1'b1;
					req_ch.mode          <= bus_items[0].beat.mode;
					req_ch.write_request <= bus_items[0].beat.write_request;
					req_ch.word_address  <= bus_items[0].beat.word_address;
					req_ch.write_data    <= bus_items[0].beat.write_data;
					req_ch.sda_in        <= bus_items[0].beat.sda_in;
					if (burst_left <= 1) begin
						// Now and then a long run with no gaps at all
						burst_left = ($urandom_range(7) == 0) ? 300 : $urandom_range(1, 40);
						gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left = burst_left - 1;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: its own stall pattern, plus one long hold-off so the
	// result register fills and the block pushes back on its input
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		rx_tick = rx_tick + 1;
		if (rx_tick % 64 == 0)
			rx_style = rx_style_t'($urandom_range(3));
		if (!hold_used && rx_beats >= HOLD_AFTER) begin
			hold_used = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			case (rx_style)
				RX_OPEN:    res_ch.ready <= 1'b1;
				RX_HALF:    res_ch.ready <= rx_tick[0];
				RX_QUARTER: res_ch.ready <= (rx_tick[1:0] == 2'd3);
				default:    res_ch.ready <= ($urandom_range(9) < 7);
			endcase
		end
	end

	initial begin
		rx_tick   = 0;
		hold_left = 0;
		hold_used = 1'b0;
		rx_style  = RX_OPEN;
		rx_beats  = 0;
		mismatches = 0;
		stall_cycles = 0;
	end

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	function automatic void report_field(string field, int want, int got);
		if (mismatches < MAX_REPORTS)
			$display("mismatch on result beat %0d: %s expected %0h got %0h",
				rx_beats, field, want, got);
		mismatches++;
	endfunction

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (levels_due.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("result beat %0d arrived with nothing outstanding", rx_beats);
				mismatches++;
			end else begin
				foreseen = levels_due.pop_front();
				if (res_ch.scl_level !== foreseen.scl)
					report_field("scl_level", foreseen.scl, res_ch.scl_level);
				if (res_ch.sda_level !== foreseen.sda)
					report_field("sda_level", foreseen.sda, res_ch.sda_level);
				if (res_ch.busy_res !== foreseen.busy)
					report_field("busy_res", foreseen.busy, res_ch.busy_res);
				if (res_ch.done_res !== foreseen.done)
					report_field("done_res", foreseen.done, res_ch.done_res);
				if (res_ch.read_byte_out !== foreseen.rd_data)
					report_field("read_byte_out", foreseen.rd_data, res_ch.read_byte_out);
			end
			rx_beats++;
		end
	end

	// Watchdog: drop out if no beat moves on either channel for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles = stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

endmodule
